// ===== rtl/core/ppc_pkg.sv =====
`timescale 1ns / 1ps

package ppc_pkg;

	// configuration register file
	localparam int NUM_REGS        = 6;
	localparam int REG_W           = 6;
	localparam int REG_INDEX_W     = 3;
	localparam int CLASSES_PER_SET = 3;

	// stream word widths
	localparam int IN_DATA_W  = 72;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 8;
	localparam int FIELD_W    = 16;
	localparam int SEL_W      = 3;
	localparam int VIDX_W     = 5;
	localparam int CLASS_W    = 2;
	localparam int CLS_IDX_W  = 2;

	// item kinds carried in tuser
	localparam logic OP_CLASSIFY = 1'b0;
	localparam logic OP_WRITE    = 1'b1;

	// class codes
	localparam logic [CLASS_W-1:0] CLASS_NONE = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_ONE  = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_TWO  = 2'd2;
	localparam logic [CLASS_W-1:0] CLASS_THREE = 2'd3;

	// index of the last class within a set
	localparam logic [CLS_IDX_W-1:0] LAST_CLASS = 2'd2;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_EDGES,
		ST_DRAIN,
		ST_RESULT
	} ppc_state_t;

	// edge unit status back to the sequencer
	typedef struct packed {
		logic busy;
		logic toggle;
	} edge_status_t;

endpackage

// ===== rtl/core/ppc_edge_unit.sv =====
`timescale 1ns / 1ps

module ppc_edge_unit
	import ppc_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  edge_valid,
	input  logic [COORD_BITS-1:0] px,
	input  logic [COORD_BITS-1:0] py,
	input  logic [COORD_BITS-1:0] cur_x,
	input  logic [COORD_BITS-1:0] cur_y,
	input  logic [COORD_BITS-1:0] prev_x,
	input  logic [COORD_BITS-1:0] prev_y,
	output edge_status_t          status
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;

	logic                 above_cur;
	logic                 above_prev;
	logic signed [DW-1:0] dy;
	logic signed [DW-1:0] dxp;
	logic signed [DW-1:0] dyp;
	logic signed [DW-1:0] dxe;
	logic signed [PW-1:0] lhs_c;
	logic signed [PW-1:0] rhs_c;

	logic                 valid_s1;
	logic                 straddle_s1;
	logic                 dypos_s1;
	logic signed [PW-1:0] lhs_s1;
	logic signed [PW-1:0] rhs_s1;
	logic                 crossing;

	// half-open straddle test and the two cross products
	always_comb begin
		above_cur  = cur_y > py;
		above_prev = prev_y > py;
		dy  = $signed({1'b0, prev_y}) - $signed({1'b0, cur_y});
		dxp = $signed({1'b0, px}) - $signed({1'b0, cur_x});
		dyp = $signed({1'b0, py}) - $signed({1'b0, cur_y});
		dxe = $signed({1'b0, prev_x}) - $signed({1'b0, cur_x});
		lhs_c = dxp * dy;
		rhs_c = dyp * dxe;
	end

	// product stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= edge_valid;
		end
	end

	// product stage payload
	always_ff @(posedge clk) begin
		straddle_s1 <= above_cur != above_prev;
		dypos_s1    <= dy > 0;
		lhs_s1      <= lhs_c;
		rhs_s1      <= rhs_c;
	end

	// crossing decision, sign of dy sets the compare direction
	always_comb begin
		crossing = dypos_s1 ? (lhs_s1 < rhs_s1) : (lhs_s1 > rhs_s1);
		status.busy   = valid_s1;
		status.toggle = valid_s1 && straddle_s1 && crossing;
	end

endmodule

// ===== rtl/core/polygon_particle_classifier_core.sv =====
`timescale 1ns / 1ps

// Point-in-polygon particle classifier. A classify word carries a point
// (stop energy, layer energy) and a set flag; the block tests the three
// polygons of that set in class order by crossing number and returns one
// word with the first class that holds the point, or 0. A vertex write word
// stores one vertex and returns nothing. Vertex counts come from the
// configuration port. The vertices sit in one synchronous RAM with a single
// read port, and one edge is read and tested per cycle; a polygon with no
// vertices is skipped without reading the RAM. A finished result waits in
// the output register while the next word is accepted. Vertices must be
// written before a polygon that uses them is classified against.
module polygon_particle_classifier_core
	import ppc_pkg::*;
#(
	parameter int MAX_VERTICES  = 32,
	parameter int POLYGON_COUNT = 6,
	parameter int COORD_BITS    = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// classify or vertex write words
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [15:0] stop_energy, [31:16] layer_energy, [34:32] polygon_select,
	// [39:35] vertex_index, [55:40] vertex_x, [71:56] vertex_y
	input  logic [IN_DATA_W-1:0]   s_tdata,
	// [0] op, [1] alt_set
	input  logic [IN_USER_W-1:0]   s_tuser,
	// result words
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [1:0] particle_class
	output logic [OUT_DATA_W-1:0]  m_tdata,
	// vertex count registers
	input  logic                   cfg_we,
	input  logic [REG_INDEX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]       cfg_data
);

	localparam int DEPTH  = POLYGON_COUNT * MAX_VERTICES;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IDX_W  = $clog2(MAX_VERTICES);
	localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
	localparam int WORD_W = 2 * COORD_BITS;

	ppc_state_t state_q, state_d;

	logic [REG_W-1:0]      count_q [NUM_REGS];

	logic                  set_q;
	logic [COORD_BITS-1:0] px_q;
	logic [COORD_BITS-1:0] py_q;
	logic [CLS_IDX_W-1:0]  cls_q;
	logic [ADDR_W-1:0]     base_q;
	logic [CNT_W-1:0]      n_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  inside_q;
	logic [CLASS_W-1:0]    res_q;
	logic                  out_valid_q;
	logic [CLASS_W-1:0]    out_class_q;

	logic [WORD_W-1:0]     mem [DEPTH];
	logic                  rd_en;
	logic [ADDR_W-1:0]     rd_addr;
	logic                  rvalid_q;
	logic                  redge_q;
	logic [WORD_W-1:0]     rdata_q;
	logic [WORD_W-1:0]     prev_q;

	logic                  accept;
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic [WORD_W-1:0]     wr_word;
	logic [SEL_W-1:0]      in_sel;
	logic [VIDX_W-1:0]     in_vidx;

	logic [SEL_W-1:0]      poly_c;
	logic                  poly_ok;
	logic [REG_W-1:0]      cnt_c;
	logic [CNT_W-1:0]      n_c;
	logic [ADDR_W-1:0]     base_c;
	logic                  issue_c;
	logic                  edges_last;
	logic                  pipe_empty;
	logic                  out_load;

	edge_status_t          status;

	assign s_tready = state_q == ST_IDLE;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - CLASS_W){1'b0}}, out_class_q};

	// vertex write decode
	always_comb begin
		in_sel  = s_tdata[34:32];
		in_vidx = s_tdata[39:35];
		wr_en   = accept && (s_tuser[0] == OP_WRITE)
			&& (32'(in_sel) < POLYGON_COUNT) && (32'(in_vidx) < MAX_VERTICES);
		wr_addr = ADDR_W'(32'(in_sel) * MAX_VERTICES + 32'(in_vidx));
		wr_word = {COORD_BITS'(s_tdata[71:56]), COORD_BITS'(s_tdata[55:40])};
	end

	// polygon lookup for the current class
	always_comb begin
		poly_c  = set_q ? SEL_W'(CLASSES_PER_SET + 32'(cls_q)) : SEL_W'(cls_q);
		poly_ok = 32'(poly_c) < POLYGON_COUNT;
		cnt_c   = count_q[poly_c];
		if (32'(cnt_c) > MAX_VERTICES) begin
			n_c = CNT_W'(MAX_VERTICES);
		end else begin
			n_c = CNT_W'(cnt_c);
		end
		base_c     = ADDR_W'(32'(poly_c) * MAX_VERTICES);
		issue_c    = poly_ok && (n_c != '0);
		edges_last = idx_q == IDX_W'(n_q - CNT_W'(1));
		pipe_empty = !rvalid_q && !status.busy;
		out_load   = !out_valid_q || m_tready;
	end

	// sequencer next state and read port
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = base_q + ADDR_W'(idx_q);
		unique case (state_q)
			ST_IDLE: begin
				if (accept && s_tuser[0] == OP_CLASSIFY) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				if (issue_c) begin
					rd_en   = 1'b1;
					rd_addr = base_c + ADDR_W'(n_c - CNT_W'(1));
					state_d = ST_EDGES;
				end else if (cls_q == LAST_CLASS) begin
					state_d = ST_RESULT;
				end
			end
			ST_EDGES: begin
				rd_en = 1'b1;
				if (edges_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (pipe_empty) begin
					if (inside_q || cls_q == LAST_CLASS) begin
						state_d = ST_RESULT;
					end else begin
						state_d = ST_SETUP;
					end
				end
			end
			ST_RESULT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cls_q       <= '0;
			inside_q    <= 1'b0;
			out_valid_q <= 1'b0;
			rvalid_q    <= 1'b0;
			redge_q     <= 1'b0;
			for (int r = 0; r < NUM_REGS; r++) begin
				count_q[r] <= '0;
			end
		end else begin
			state_q  <= state_d;
			rvalid_q <= rd_en;
			redge_q  <= rd_en && (state_q == ST_EDGES);

			if (cfg_we && 32'(cfg_index) < NUM_REGS) begin
				count_q[cfg_index] <= cfg_data;
			end

			if (accept && s_tuser[0] == OP_CLASSIFY) begin
				cls_q <= '0;
			end else if (state_q == ST_SETUP && !issue_c && cls_q != LAST_CLASS) begin
				cls_q <= cls_q + CLS_IDX_W'(1);
			end else if (state_q == ST_DRAIN && pipe_empty && !inside_q
				&& cls_q != LAST_CLASS) begin
				cls_q <= cls_q + CLS_IDX_W'(1);
			end

			// crossing parity, cleared at the start of each polygon
			if (state_q == ST_SETUP) begin
				inside_q <= 1'b0;
			end else if (status.toggle) begin
				inside_q <= !inside_q;
			end

			// output register
			if (state_q == ST_RESULT && out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && s_tuser[0] == OP_CLASSIFY) begin
			set_q <= s_tuser[1];
			px_q  <= COORD_BITS'(s_tdata[15:0]);
			py_q  <= COORD_BITS'(s_tdata[31:16]);
		end
		if (state_q == ST_SETUP) begin
			base_q <= base_c;
			n_q    <= n_c;
			idx_q  <= '0;
			if (!issue_c) begin
				res_q <= CLASS_NONE;
			end
		end else if (state_q == ST_EDGES) begin
			idx_q <= idx_q + IDX_W'(1);
		end
		if (state_q == ST_DRAIN && pipe_empty) begin
			res_q <= inside_q ? (CLASS_W'(cls_q) + CLASS_ONE) : CLASS_NONE;
		end
		if (state_q == ST_RESULT && out_load) begin
			out_class_q <= res_q;
		end
		if (rvalid_q) begin
			prev_q <= rdata_q;
		end
	end

	// vertex memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_word;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// edge between the vertex just read and the one before it
	ppc_edge_unit #(
		.COORD_BITS(COORD_BITS)
	) u_edge (
		.clk       (clk),
		.arst_n    (arst_n),
		.edge_valid(rvalid_q && redge_q),
		.px        (px_q),
		.py        (py_q),
		.cur_x     (rdata_q[COORD_BITS-1:0]),
		.cur_y     (rdata_q[WORD_W-1:COORD_BITS]),
		.prev_x    (prev_q[COORD_BITS-1:0]),
		.prev_y    (prev_q[WORD_W-1:COORD_BITS]),
		.status    (status)
	);

	// memory is never read and written in the same cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("vertex memory read and write overlap");

	// edge pipeline only runs while a polygon is walked
	a_busy_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		status.busy |-> (state_q == ST_EDGES || state_q == ST_DRAIN))
		else $error("edge unit busy outside polygon walk");

	// nothing in flight when a new word can be taken
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!rvalid_q && !status.busy))
		else $error("edge pipeline not empty at idle");

	// edge index stays within the polygon
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EDGES) |-> (CNT_W'(idx_q) < n_q))
		else $error("edge index beyond vertex count");

	// a walk ends with a result or the next class
	a_drain_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && pipe_empty)
		|=> (state_q == ST_RESULT || state_q == ST_SETUP))
		else $error("drain left to unexpected state");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import ppc_pkg::*;

	localparam int MAX_VERTS     = 32;
	localparam int POLY_COUNT    = 6;
	localparam int COORD_MAX     = 65535;
	localparam int COUNT_MAX     = 63;
	localparam int SETTLE_CYCLES = 150;
	localparam int ROUNDS        = 6;
	localparam int ROUND_ITEMS   = 80;
	localparam int CALM_ROUND    = 3;
	localparam int PAUSE_ROUND   = 2;
	localparam longint TIMEOUT_NS = 64'd10_000_000;

	// count register indexes with no register behind them
	localparam logic [REG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [REG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

	// polygons of the fixed shapes
	localparam int RECT_POLY      = 0;
	localparam int SQUARE_POLY    = 1;
	localparam int TRIANGLE_POLY  = 2;
	localparam int PAIR_POLY      = 3;
	localparam int SINGLE_POLY    = 4;
	localparam int SATURATED_POLY = 5;

	// input word layout, stop_energy in the lowest bits
	typedef struct packed {
		logic [FIELD_W-1:0] vertex_y;
		logic [FIELD_W-1:0] vertex_x;
		logic [VIDX_W-1:0]  vertex_index;
		logic [SEL_W-1:0]   polygon_select;
		logic [FIELD_W-1:0] layer_energy;
		logic [FIELD_W-1:0] stop_energy;
	} hit_word_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata;
	logic [IN_USER_W-1:0]   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic                   cfg_we;
	logic [REG_INDEX_W-1:0] cfg_index;
	logic [REG_W-1:0]       cfg_data;

	// mirror of the vertex store and the count registers
	logic [FIELD_W-1:0] vert_x [POLY_COUNT*MAX_VERTS];
	logic [FIELD_W-1:0] vert_y [POLY_COUNT*MAX_VERTS];
	logic [REG_W-1:0]   vert_count [NUM_REGS];
	int                 next_count [NUM_REGS];

	// rough placement of each polygon, used to aim points
	int poly_cx [POLY_COUNT];
	int poly_cy [POLY_COUNT];
	int poly_rad [POLY_COUNT];
	int shape_size [POLY_COUNT];

	logic [CLASS_W-1:0] pending_classes [$];
	logic [CLASS_W-1:0] expected_class;
	int                 errors;
	bit                 calm;
	int                 ready_stall;

	polygon_particle_classifier_core #(
		.MAX_VERTICES (MAX_VERTS),
		.POLYGON_COUNT(POLY_COUNT),
		.COORD_BITS   (FIELD_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("RESULT: ERROR");
		$finish;
	end

	// crossing-number test of one polygon, half-open on y
	function automatic logic polygon_holds(input int poly, input longint px, input longint py);
		int     n;
		int     j;
		logic   parity;
		longint xi, yi, xj, yj, dy, lhs, rhs;
		logic   crossed;
		parity = 1'b0;
		n = int'(vert_count[poly]);
		if (n > MAX_VERTS)
			n = MAX_VERTS;
		j = n - 1;
		for (int i = 0; i < n; i++) begin
			xi = longint'(vert_x[poly*MAX_VERTS + i]);
			yi = longint'(vert_y[poly*MAX_VERTS + i]);
			xj = longint'(vert_x[poly*MAX_VERTS + j]);
			yj = longint'(vert_y[poly*MAX_VERTS + j]);
			if ((yi > py) != (yj > py)) begin
				dy = yj - yi;
				lhs = (px - xi) * dy;
				rhs = (py - yi) * (xj - xi);
				crossed = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
				if (crossed)
					parity = !parity;
			end
			j = i;
		end
		return parity;
	endfunction

	// first class of the selected set whose polygon holds the hit
	function automatic logic [CLASS_W-1:0] classify_hit(input logic alt,
			input logic [FIELD_W-1:0] px, input logic [FIELD_W-1:0] py);
		int base;
		base = alt ? CLASSES_PER_SET : 0;
		if (polygon_holds(base, longint'(px), longint'(py)))
			return CLASS_ONE;
		else if (polygon_holds(base + 1, longint'(px), longint'(py)))
			return CLASS_TWO;
		else if (polygon_holds(base + 2, longint'(px), longint'(py)))
			return CLASS_THREE;
		else
			return CLASS_NONE;
	endfunction

	function automatic logic [FIELD_W-1:0] clamp_coord(input int v);
		if (v < 0)
			return '0;
		if (v > COORD_MAX)
			return FIELD_W'(COORD_MAX);
		return v[FIELD_W-1:0];
	endfunction

	function automatic int extreme_coord();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return COORD_MAX;
			default: return int'($urandom_range(0, COORD_MAX));
		endcase
	endfunction

	function automatic int draw_wait();
		if (calm)
			return 0;
		return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 15));
	endfunction

	// send one word and update the mirror when it is taken
	task automatic send_word(input logic op, input logic alt, input hit_word_t w);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		s_tuser <= {alt, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op == OP_WRITE) begin
			if (w.polygon_select < POLY_COUNT) begin
				vert_x[w.polygon_select*MAX_VERTS + w.vertex_index] = w.vertex_x;
				vert_y[w.polygon_select*MAX_VERTS + w.vertex_index] = w.vertex_y;
			end
		end else begin
			pending_classes.push_back(classify_hit(alt, w.stop_energy, w.layer_energy));
		end
	endtask

	// classify word, write fields carry noise
	task automatic send_hit(input logic alt, input int px, input int py);
		hit_word_t  w;
		logic [95:0] noise;
		noise = {$urandom, $urandom, $urandom};
		w = noise[IN_DATA_W-1:0];
		w.stop_energy = clamp_coord(px);
		w.layer_energy = clamp_coord(py);
		send_word(OP_CLASSIFY, alt, w);
	endtask

	// vertex write word, classify fields carry noise
	task automatic send_vertex(input int sel, input int idx, input int x, input int y);
		hit_word_t  w;
		logic [95:0] noise;
		noise = {$urandom, $urandom, $urandom};
		w = noise[IN_DATA_W-1:0];
		w.polygon_select = sel[SEL_W-1:0];
		w.vertex_index = idx[VIDX_W-1:0];
		w.vertex_x = clamp_coord(x);
		w.vertex_y = clamp_coord(y);
		send_word(OP_WRITE, 1'($urandom_range(0, 1)), w);
	endtask

	// stop sending and wait until every class word is back
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_classes.size() != 0) @(posedge clk);
	endtask

	// block idle, including a trailing vertex write
	task automatic quiesce();
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all count registers, then the two unused indexes
	task automatic apply_counts();
		for (int idx = 0; idx < NUM_REGS; idx++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[REG_INDEX_W-1:0];
			cfg_data <= next_count[idx][REG_W-1:0];
			@(posedge clk);
			vert_count[idx] = next_count[idx][REG_W-1:0];
		end
		cfg_index <= REG_SPARE_A;
		cfg_data <= REG_W'($urandom);
		@(posedge clk);
		cfg_index <= REG_SPARE_B;
		cfg_data <= REG_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// star-shaped polygon around a random center, clipped to the coordinate range
	task automatic build_star(input int poly, input int n);
		real ang;
		int  rr;
		poly_cx[poly] = $urandom_range(0, COORD_MAX);
		poly_cy[poly] = $urandom_range(0, COORD_MAX);
		poly_rad[poly] = $urandom_range(500, 24000);
		shape_size[poly] = n;
		for (int k = 0; k < n; k++) begin
			ang = 6.2831853 * (k + 0.8 * ($urandom_range(0, 100) / 100.0 - 0.5)) / n;
			rr = poly_rad[poly] / 2 + int'($urandom_range(0, poly_rad[poly] / 2));
			send_vertex(poly, k, poly_cx[poly] + $rtoi(rr * $cos(ang)),
				poly_cy[poly] + $rtoi(rr * $sin(ang)));
		end
	endtask

	// point aimed at one polygon of the set: anywhere, near it, at a vertex, on an edge
	task automatic pick_point(input logic alt, output int px, output int py);
		int p, n, i, i2, cx, cy, rad;
		p = (alt ? CLASSES_PER_SET : 0) + int'($urandom_range(0, CLASSES_PER_SET - 1));
		n = int'(vert_count[p]);
		if (n > MAX_VERTS)
			n = MAX_VERTS;
		if (n == 0)
			n = 1;
		i = $urandom_range(0, n - 1);
		i2 = (i + 1) % n;
		i = p*MAX_VERTS + i;
		i2 = p*MAX_VERTS + i2;
		cx = poly_cx[p];
		cy = poly_cy[p];
		rad = poly_rad[p];
		case ($urandom_range(0, 9))
			0: begin
				px = $urandom_range(0, COORD_MAX);
				py = $urandom_range(0, COORD_MAX);
			end
			1: begin
				px = extreme_coord();
				py = extreme_coord();
			end
			2, 3, 4: begin
				px = cx + int'($urandom_range(0, 2*rad)) - rad;
				py = cy + int'($urandom_range(0, 2*rad)) - rad;
			end
			5, 6: begin
				px = int'(vert_x[i]);
				py = int'(vert_y[i]);
			end
			7: begin
				px = int'(vert_x[i]) + int'($urandom_range(0, 6)) - 3;
				py = int'(vert_y[i]) + int'($urandom_range(0, 6)) - 3;
			end
			8: begin
				px = (int'(vert_x[i]) + int'(vert_x[i2])) / 2;
				py = (int'(vert_y[i]) + int'(vert_y[i2])) / 2;
			end
			default: begin
				px = cx + int'($urandom_range(0, 2*rad)) - rad;
				py = int'(vert_y[i]);
			end
		endcase
	endtask

	// counts at reset: nothing ever matches
	task automatic check_reset_state();
		send_hit(1'b0, 0, 0);
		send_hit(1'b0, COORD_MAX, COORD_MAX);
		send_hit(1'b1, 0, COORD_MAX);
		send_hit(1'b1, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
	endtask

	// fill every vertex entry, plus writes to polygons that do not exist
	task automatic load_vertex_store();
		for (int p = 0; p < POLY_COUNT; p++)
			build_star(p, MAX_VERTS);
		for (int k = 0; k < 4; k++)
			send_vertex($urandom_range(POLY_COUNT, 2**SEL_W - 1), $urandom_range(0, MAX_VERTS - 1),
				$urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
	endtask

	// rectangle, corner square, triangle; short and oversized counts in the other set
	task automatic check_fixed_shapes();
		quiesce();
		send_vertex(RECT_POLY, 0, 'h1000, 'h1000);
		send_vertex(RECT_POLY, 1, 'h3000, 'h1000);
		send_vertex(RECT_POLY, 2, 'h3000, 'h3000);
		send_vertex(RECT_POLY, 3, 'h1000, 'h3000);
		send_vertex(SQUARE_POLY, 0, 'h8000, 'h8000);
		send_vertex(SQUARE_POLY, 1, COORD_MAX, 'h8000);
		send_vertex(SQUARE_POLY, 2, COORD_MAX, COORD_MAX);
		send_vertex(SQUARE_POLY, 3, 'h8000, COORD_MAX);
		send_vertex(TRIANGLE_POLY, 0, 0, 0);
		send_vertex(TRIANGLE_POLY, 1, 'h7FFF, 0);
		send_vertex(TRIANGLE_POLY, 2, 0, 'h7FFF);
		poly_cx[RECT_POLY] = 'h2000;
		poly_cy[RECT_POLY] = 'h2000;
		poly_rad[RECT_POLY] = 'h1000;
		poly_cx[SQUARE_POLY] = 'hC000;
		poly_cy[SQUARE_POLY] = 'hC000;
		poly_rad[SQUARE_POLY] = 'h4000;
		poly_cx[TRIANGLE_POLY] = 'h2000;
		poly_cy[TRIANGLE_POLY] = 'h2000;
		poly_rad[TRIANGLE_POLY] = 'h3000;
		quiesce();
		next_count[RECT_POLY] = 4;
		next_count[SQUARE_POLY] = 4;
		next_count[TRIANGLE_POLY] = 3;
		next_count[PAIR_POLY] = 2;
		next_count[SINGLE_POLY] = 1;
		next_count[SATURATED_POLY] = COUNT_MAX;
		apply_counts();
		// interior, each edge, a corner, then the other shapes and the extremes
		send_hit(1'b0, 'h2000, 'h2000);
		send_hit(1'b0, 'h1000, 'h2000);
		send_hit(1'b0, 'h3000, 'h2000);
		send_hit(1'b0, 'h2000, 'h1000);
		send_hit(1'b0, 'h2000, 'h3000);
		send_hit(1'b0, 'h1000, 'h1000);
		send_hit(1'b0, 'h0800, 'h0800);
		send_hit(1'b0, 0, 0);
		send_hit(1'b0, 'hC000, 'hC000);
		send_hit(1'b0, COORD_MAX, COORD_MAX);
		send_hit(1'b0, 'h8000, 'hC000);
		send_hit(1'b0, 'h9000, 'h1000);
		send_hit(1'b1, poly_cx[PAIR_POLY], poly_cy[PAIR_POLY]);
		send_hit(1'b1, COORD_MAX, 0);
	endtask

	// reshape some polygons, pick new counts, then a mix of hits and vertex writes
	task automatic run_random_round(input int round);
		int px, py;
		quiesce();
		calm = (round == CALM_ROUND);
		if (round > 0) begin
			for (int p = 0; p < POLY_COUNT; p++)
				if ($urandom_range(0, 1))
					build_star(p, ($urandom_range(0, 7) == 0) ? MAX_VERTS :
						int'($urandom_range(3, 12)));
			quiesce();
		end
		for (int p = 0; p < POLY_COUNT; p++) begin
			if (round == 0)
				next_count[p] = $urandom_range(0, 1) ? MAX_VERTS :
					int'($urandom_range(MAX_VERTS + 1, COUNT_MAX));
			else
				case ($urandom_range(0, 9))
					0: next_count[p] = 0;
					1: next_count[p] = $urandom_range(1, 2);
					2: next_count[p] = $urandom_range(MAX_VERTS, COUNT_MAX);
					default: next_count[p] = shape_size[p];
				endcase
		end
		apply_counts();
		for (int k = 0; k < ROUND_ITEMS; k++) begin
			// occasional write to a polygon that does not exist
			if ($urandom_range(0, 19) == 0)
				send_vertex($urandom_range(POLY_COUNT, 2**SEL_W - 1),
					$urandom_range(0, MAX_VERTS - 1),
					$urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
			if ($urandom_range(0, 9) == 0) begin
				px = $urandom_range(0, POLY_COUNT - 1);
				if ($urandom_range(0, 1))
					send_vertex(px, $urandom_range(0, MAX_VERTS - 1),
						$urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
				else
					send_vertex(px, $urandom_range(0, MAX_VERTS - 1),
						poly_cx[px] + int'($urandom_range(0, 2*poly_rad[px])) - poly_rad[px],
						poly_cy[px] + int'($urandom_range(0, 2*poly_rad[px])) - poly_rad[px]);
			end else begin
				py = $urandom_range(0, 1);
				pick_point(py[0], px, py);
				send_hit(1'($urandom_range(0, 1)), px, py);
			end
			// source holds off until the pipeline is empty
			if (round == PAUSE_ROUND && k == ROUND_ITEMS / 2)
				wait_for_results();
		end
	endtask

	// result ready, random stalls per word
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			ready_stall = draw_wait();
			if (ready_stall > 0) begin
				m_tready <= 1'b0;
				repeat (ready_stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// compare each result word with the oldest pending class
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_classes.size() == 0) begin
				$display("%0t: result word with nothing pending, expected none, actual %0d",
					$time, m_tdata);
				errors++;
			end else begin
				expected_class = pending_classes.pop_front();
				if (m_tdata !== {{(OUT_DATA_W-CLASS_W){1'b0}}, expected_class}) begin
					$display("%0t: class mismatch, expected %0d, actual %0d",
						$time, expected_class, m_tdata);
					errors++;
				end
			end
		end
	end

	// main sequence
	initial begin
		errors = 0;
		calm = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		for (int p = 0; p < NUM_REGS; p++)
			vert_count[p] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_reset_state();
		load_vertex_store();
		check_fixed_shapes();
		for (int round = 0; round < ROUNDS; round++)
			run_random_round(round);

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_classes.size() != 0) begin
			$display("%0t: %0d class words never arrived, expected %0d, actual none",
				$time, pending_classes.size(), pending_classes[0]);
			errors++;
		end
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
